### sv/art_pkg.sv
package art_pkg;

  // Number of table slots and the width of a slot index.
  localparam int unsigned SLOTS = 8;
  localparam int unsigned SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Width of the slot field in a result transaction.
  localparam int unsigned SlotFieldW = 3;

  // Configuration register map, indexed by paddr[2].
  localparam logic RegAckTimeout = 1'b0;
  localparam logic RegRetryLimit = 1'b1;

  localparam logic [15:0] AckTimeoutRst = 16'd5;
  localparam logic [7:0]  RetryLimitRst = 8'd3;

  typedef enum logic [1:0] {
    CmdTrack = 2'd0,
    CmdAck   = 2'd1,
    CmdNack  = 2'd2,
    CmdTick  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KindTracked   = 3'd0,
    KindTableFull = 3'd1,
    KindFreed     = 3'd2,
    KindNoMatch   = 3'd3,
    KindRetx      = 3'd4,
    KindGaveUp    = 3'd5,
    KindTickDone  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StScan   = 2'd1,
    StFinish = 2'd2
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  message_id;
    logic [15:0] frame_handle;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    kind_e                 kind;
    logic [SlotFieldW-1:0] slot;
    logic [7:0]            out_message_id;
    logic [15:0]           out_frame_handle;
    logic                  last;
  } res_t;

  // One slot of the table as held in the slot memory.
  typedef struct packed {
    logic [7:0]  message_id;
    logic [15:0] handle;
    logic [31:0] sent_time;
    logic [7:0]  retries;
  } entry_t;

  // Verdict of the compare unit on the slot under evaluation.
  typedef struct packed {
    logic match;
    logic due;
    logic can_retry;
  } eval_t;

endpackage

### sv/art_slot_mem.sv
module art_slot_mem (
  input  logic                       clk_i,
  input  logic [art_pkg::SlotW-1:0]  rd_addr_i,
  output art_pkg::entry_t            rd_data_o,
  input  logic                       wr_en_i,
  input  logic [art_pkg::SlotW-1:0]  wr_addr_i,
  input  art_pkg::entry_t            wr_data_i
);

  art_pkg::entry_t slot_mem_q [art_pkg::SLOTS];
  art_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= slot_mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/art_cmp_unit.sv
module art_cmp_unit (
  input  logic            used_i,
  input  art_pkg::entry_t entry_i,
  input  logic [7:0]      message_id_i,
  input  logic [31:0]     now_i,
  input  logic [15:0]     ack_timeout_i,
  input  logic [7:0]      retry_limit_i,
  output art_pkg::eval_t  eval_o
);

  logic [31:0] age;

  // Age wraps modulo 2^32, so a plain subtraction does the job.
  assign age              = now_i - entry_i.sent_time;
  assign eval_o.match     = used_i && (entry_i.message_id == message_id_i);
  assign eval_o.due       = used_i && (age >= {16'd0, ack_timeout_i});
  assign eval_o.can_retry = entry_i.retries < retry_limit_i;

endmodule

### sv/art_ctrl.sv
module art_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  art_pkg::in_t  in_i,
  input  logic [15:0]   ack_timeout_i,
  input  logic [7:0]    retry_limit_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output art_pkg::res_t res_o
);

  localparam logic [art_pkg::SlotW-1:0] LastIdx = art_pkg::SlotW'(art_pkg::SLOTS - 1);

  art_pkg::state_e            state_q, state_d;
  logic [art_pkg::SlotW-1:0]  rd_idx_q, rd_idx_d;
  logic                       rd_done_q, rd_done_d;
  logic                       ev_vld_q, ev_vld_d;
  logic [art_pkg::SlotW-1:0]  ev_idx_q, ev_idx_d;
  logic [art_pkg::SLOTS-1:0]  used_q, used_d;
  logic                       res_vld_q, res_vld_d;
  art_pkg::res_t              res_q, res_d;
  art_pkg::in_t               in_q;

  art_pkg::entry_t            rd_data;
  logic                       wr_en;
  art_pkg::entry_t            wr_data;
  art_pkg::eval_t             ev;

  art_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (ev_idx_q),
    .wr_data_i (wr_data)
  );

  art_cmp_unit u_cmp_unit (
    .used_i        (used_q[ev_idx_q]),
    .entry_i       (rd_data),
    .message_id_i  (in_q.message_id),
    .now_i         (in_q.now),
    .ack_timeout_i (ack_timeout_i),
    .retry_limit_i (retry_limit_i),
    .eval_o        (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= art_pkg::StIdle;
      rd_idx_q  <= '0;
      rd_done_q <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      used_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      rd_done_q <= rd_done_d;
      ev_vld_q  <= ev_vld_d;
      ev_idx_q  <= ev_idx_d;
      used_q    <= used_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == art_pkg::StIdle && start_i) begin
      in_q <= in_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    rd_idx_d  = rd_idx_q;
    rd_done_d = rd_done_q;
    ev_vld_d  = 1'b0;
    ev_idx_d  = ev_idx_q;
    used_d    = used_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    wr_en     = 1'b0;
    wr_data   = rd_data;

    case (state_q)
      art_pkg::StIdle: begin
        if (start_i) begin
          state_d   = art_pkg::StScan;
          rd_idx_d  = '0;
          rd_done_d = 1'b0;
        end
      end

      art_pkg::StScan: begin
        // Issue the read of the next slot while the previous one is evaluated.
        if (!rd_done_q) begin
          ev_vld_d  = 1'b1;
          ev_idx_d  = rd_idx_q;
          rd_idx_d  = rd_idx_q + 1'b1;
          rd_done_d = (rd_idx_q == LastIdx);
        end
        if (ev_vld_q) begin
          res_d.slot = art_pkg::SlotFieldW'(ev_idx_q);
          res_d.last = 1'b0;
          case (in_q.cmd)
            art_pkg::CmdTrack: begin
              if (!used_q[ev_idx_q]) begin
                used_d[ev_idx_q]       = 1'b1;
                wr_en                  = 1'b1;
                wr_data.message_id     = in_q.message_id;
                wr_data.handle         = in_q.frame_handle;
                wr_data.sent_time      = in_q.now;
                wr_data.retries        = '0;
                res_vld_d              = 1'b1;
                res_d.kind             = art_pkg::KindTracked;
                res_d.out_message_id   = in_q.message_id;
                res_d.out_frame_handle = in_q.frame_handle;
                res_d.last             = 1'b1;
                state_d                = art_pkg::StIdle;
              end
            end
            art_pkg::CmdAck, art_pkg::CmdNack: begin
              if (ev.match) begin
                used_d[ev_idx_q]       = 1'b0;
                res_vld_d              = 1'b1;
                res_d.kind             = art_pkg::KindFreed;
                res_d.out_message_id   = rd_data.message_id;
                res_d.out_frame_handle = rd_data.handle;
                res_d.last             = 1'b1;
                state_d                = art_pkg::StIdle;
              end
            end
            art_pkg::CmdTick: begin
              if (ev.due) begin
                res_vld_d              = 1'b1;
                res_d.out_message_id   = rd_data.message_id;
                res_d.out_frame_handle = rd_data.handle;
                if (ev.can_retry) begin
                  wr_en             = 1'b1;
                  wr_data.sent_time = in_q.now;
                  wr_data.retries   = rd_data.retries + 8'd1;
                  res_d.kind        = art_pkg::KindRetx;
                end else begin
                  used_d[ev_idx_q] = 1'b0;
                  res_d.kind       = art_pkg::KindGaveUp;
                end
              end
            end
            default: begin
            end
          endcase
          if (ev_idx_q == LastIdx && state_d == art_pkg::StScan) begin
            state_d = art_pkg::StFinish;
          end
        end
      end

      art_pkg::StFinish: begin
        res_vld_d              = 1'b1;
        res_d.slot             = '0;
        res_d.last             = 1'b1;
        res_d.out_message_id   = '0;
        res_d.out_frame_handle = '0;
        state_d                = art_pkg::StIdle;
        case (in_q.cmd)
          art_pkg::CmdTrack: begin
            res_d.kind             = art_pkg::KindTableFull;
            res_d.out_message_id   = in_q.message_id;
            res_d.out_frame_handle = in_q.frame_handle;
          end
          art_pkg::CmdAck, art_pkg::CmdNack: begin
            res_d.kind           = art_pkg::KindNoMatch;
            res_d.out_message_id = in_q.message_id;
          end
          default: begin
            res_d.kind = art_pkg::KindTickDone;
          end
        endcase
      end

      default: begin
        state_d = art_pkg::StIdle;
      end
    endcase
  end

  assign busy_o      = (state_q != art_pkg::StIdle);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // The final result of a transaction is issued together with the return to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.last |-> state_q == art_pkg::StIdle)
    else $error("last result issued while still busy");

  // An accepted command makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not start a scan");

  // A tracked slot is marked used when the result appears.
  a_tracked_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.kind == art_pkg::KindTracked |-> used_q[res_q.slot])
    else $error("tracked slot not marked used");

  // Only timer events may be followed by further results of the same command.
  a_not_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_q.last |->
      (res_q.kind == art_pkg::KindRetx || res_q.kind == art_pkg::KindGaveUp))
    else $error("non-final result of an unexpected kind");

endmodule

### sv/ack_retransmit_tracker.sv
// Retransmission tracker for an acknowledged message link.
//
// A command transaction is accepted at a rising edge where start is high and
// busy is low. Track stores a message in the lowest free slot, ack and nack
// free the lowest used slot holding the given id, and tick walks every slot
// and raises a retransmit or give-up event for each slot whose age reached
// the acknowledge timeout, followed by a tick-done result.
//
// Results leave on res_o, each marked by res_valid_o for exactly one cycle;
// the receiver cannot hold them off, so it must take every one. The last
// result of a command carries the last flag.
//
// A single compare unit looks at one slot per cycle, fed from a slot memory
// with a registered read port. A command that finds its slot ends the scan;
// a tick, a full table or a failed ack walks all SLOTS slots and issues its
// final result from the finish state. The last result shows in the first
// cycle with busy low, and a new command may be accepted in that same cycle.
// Reset empties the table and loads ack_timeout = 5 and retry_limit = 3.
// The APB port holds ack_timeout at byte address 0 and retry_limit at 4; it
// should only be written while the block is idle.
module ack_retransmit_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  art_pkg::in_t  in_i,
  output logic          res_valid_o,
  output art_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [15:0] ack_timeout_q;
  logic [7:0]  retry_limit_q;
  logic        cfg_wr;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= art_pkg::AckTimeoutRst;
      retry_limit_q <= art_pkg::RetryLimitRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        art_pkg::RegAckTimeout: ack_timeout_q <= pwdata[15:0];
        art_pkg::RegRetryLimit: retry_limit_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is returned with the low bits of the register, zero above.
  always_comb begin
    case (paddr[2])
      art_pkg::RegAckTimeout: prdata = {16'd0, ack_timeout_q};
      art_pkg::RegRetryLimit: prdata = {24'd0, retry_limit_q};
      default:                prdata = '0;
    endcase
  end

  // The sequencer owns the slot table and walks it one slot per cycle.
  art_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .in_i          (in_i),
    .ack_timeout_i (ack_timeout_q),
    .retry_limit_i (retry_limit_q),
    .busy_o        (busy),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o)
  );

endmodule
